### src/lrb_pkg.sv
// lrb_pkg: shared types and constants for the log ring buffer with level tags.
// Request and status codes, tag characters and the front-to-back command item.
// No dependencies.
package lrb_pkg;

  // Request codes
  localparam logic [2:0] REQ_WRITE       = 3'd0;
  localparam logic [2:0] REQ_READ_NEXT   = 3'd1;
  localparam logic [2:0] REQ_READ_RECENT = 3'd2;
  localparam logic [2:0] REQ_COUNT       = 3'd3;
  localparam logic [2:0] REQ_CLEAR       = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;

  // Tag characters
  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam int MAX_BURST = 6;

  // Classified item: request code plus the bytes a write puts into the ring
  typedef struct packed {
    logic [2:0]                kind;
    logic [2:0]                nbytes;
    logic [MAX_BURST-1:0][7:0] bytes;
  } lrb_cmd_t;

endpackage

### src/lrb_if.sv
// lrb_if: valid/ready channel interfaces for requests and responses.
// Depends on nothing; widths of the ring-sized fields are interface parameters.
interface lrb_req_if #(
  parameter int OW = 14
) ();
  logic          valid;
  logic          ready;
  logic [2:0]    req_type;
  logic [7:0]    data_byte;
  logic          last_of_message;
  logic [OW-1:0] back_offset;

  modport source (output valid, req_type, data_byte, last_of_message, back_offset,
                  input ready);
  modport sink   (input valid, req_type, data_byte, last_of_message, back_offset,
                  output ready);
endinterface

interface lrb_rsp_if #(
  parameter int CW = 15
) ();
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [7:0]    read_byte;
  logic [CW-1:0] unread_count;

  modport source (output valid, status, read_byte, unread_count, input ready);
  modport sink   (input valid, status, read_byte, unread_count, output ready);
endinterface

### src/lrb_front.sv
// lrb_front: accepts requests, tracks line-start tag state and expands write
// bytes into the byte burst the ring must store. Depends on lrb_pkg.
module lrb_front import lrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  input  logic       take,
  input  logic [2:0] req_type,
  input  logic [7:0] data_byte,
  input  logic       last_of_message,
  output lrb_cmd_t   cmd
);

  logic       at_line_start, at_line_start_next;
  logic [1:0] held_count, held_count_next;
  logic [2:0] held_digit, held_digit_next;
  logic [2:0] default_level;
  logic [7:0] dl_char, hd_char;
  logic       is_digit, is_nl;

  assign dl_char  = CH_ZERO | {5'd0, default_level};
  assign hd_char  = CH_ZERO | {5'd0, held_digit};
  assign is_digit = (data_byte[7:3] == CH_ZERO[7:3]);
  assign is_nl    = (data_byte == CH_NL);

  // Classify the item and build the byte burst
  always_comb begin
    at_line_start_next = at_line_start;
    held_count_next    = held_count;
    held_digit_next    = held_digit;
    cmd.kind   = req_type;
    cmd.nbytes = 3'd0;
    cmd.bytes  = '0;
    if (req_type == REQ_WRITE) begin
      if (!at_line_start) begin
        cmd.nbytes = 3'd1;
        cmd.bytes[0] = data_byte;
        at_line_start_next = is_nl;
      end else begin
        unique case (held_count)
          2'd1: begin
            if (is_digit && !last_of_message) begin
              held_digit_next = data_byte[2:0];
              held_count_next = 2'd2;
            end else begin
              cmd.nbytes = 3'd5;
              cmd.bytes[0] = CH_OPEN;
              cmd.bytes[1] = dl_char;
              cmd.bytes[2] = CH_CLOSE;
              cmd.bytes[3] = CH_OPEN;
              cmd.bytes[4] = data_byte;
              held_count_next = 2'd0;
              at_line_start_next = is_nl;
            end
          end
          2'd2: begin
            held_count_next = 2'd0;
            if (data_byte == CH_CLOSE) begin
              cmd.nbytes = 3'd3;
              cmd.bytes[0] = CH_OPEN;
              cmd.bytes[1] = hd_char;
              cmd.bytes[2] = CH_CLOSE;
              at_line_start_next = 1'b0;
            end else begin
              cmd.nbytes = 3'd6;
              cmd.bytes[0] = CH_OPEN;
              cmd.bytes[1] = dl_char;
              cmd.bytes[2] = CH_CLOSE;
              cmd.bytes[3] = CH_OPEN;
              cmd.bytes[4] = hd_char;
              cmd.bytes[5] = data_byte;
              at_line_start_next = is_nl;
            end
          end
          default: begin
            if (data_byte == CH_OPEN && !last_of_message) begin
              held_count_next = 2'd1;
            end else begin
              cmd.nbytes = 3'd4;
              cmd.bytes[0] = CH_OPEN;
              cmd.bytes[1] = dl_char;
              cmd.bytes[2] = CH_CLOSE;
              cmd.bytes[3] = data_byte;
              held_count_next = 2'd0;
              at_line_start_next = is_nl;
            end
          end
        endcase
      end
    end
  end

  // Line state and default level register
  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      held_count    <= 2'd0;
      held_digit    <= 3'd0;
      default_level <= 3'd4;
    end else begin
      if (take) begin
        at_line_start <= at_line_start_next;
        held_count    <= held_count_next;
        held_digit    <= held_digit_next;
      end
      if (cfg_we) begin
        default_level <= cfg_wdata;
      end
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst) held_count != 2'd3)
    else $error("held count out of range");
  a_held_needs_start: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> at_line_start)
    else $error("bytes held outside line start");
  a_write_len: assert property (@(posedge clk) disable iff (rst)
    take && req_type != REQ_WRITE |-> cmd.nbytes == 3'd0)
    else $error("burst on non-write request");

endmodule

### src/lrb_queue.sv
// lrb_queue: two-entry queue between front and back.
// Carries the classified command and the read-back offset. Depends on lrb_pkg.
module lrb_queue import lrb_pkg::*; #(
  parameter int OW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lrb_cmd_t      push_cmd,
  input  logic [OW-1:0] push_off,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output lrb_cmd_t      head_cmd,
  output logic [OW-1:0] head_off
);

  localparam int QD = 2;

  lrb_cmd_t      cmd_q [QD];
  logic [OW-1:0] off_q [QD];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign full     = (count == 2'(QD));
  assign nonempty = (count != 2'd0);
  assign head_cmd = cmd_q[rd_ptr];
  assign head_off = off_q[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr] <= push_cmd;
      off_q[wr_ptr] <= push_off;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'(QD))
    else $error("queue count out of range");

endmodule

### src/lrb_back.sv
// lrb_back: executes commands against the byte ring and holds the response.
// Owns the ring memory, slot pointers, unread and recent counts. Depends on lrb_pkg.
module lrb_back import lrb_pkg::*; #(
  parameter int LOG_DEPTH = 16384,
  parameter int AW        = 14,
  parameter int CW        = 15,
  parameter int OW        = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  lrb_cmd_t      q_cmd,
  input  logic [OW-1:0] q_off,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [7:0]    out_byte,
  output logic [CW-1:0] out_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WR   = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;

  localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(LOG_DEPTH);

  logic [7:0] mem [LOG_DEPTH];
  logic [7:0] rdata;

  logic [1:0]    state, state_next;
  lrb_cmd_t      cmd, cmd_next;
  logic [2:0]    wr_idx, wr_idx_next;
  logic [AW-1:0] wslot, wslot_next, rslot, rslot_next;
  logic [CW-1:0] unread, unread_next, recent, recent_next;
  logic          out_valid_next;
  logic [1:0]    out_status_next;
  logic [7:0]    out_byte_next;
  logic [CW-1:0] out_count_next;

  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wbyte;

  logic          out_free;
  logic [CW-1:0] k_ext, kp1;
  logic [CW:0]   back_sum;
  logic [AW-1:0] recent_addr;

  assign out_free = !out_valid || out_ready;
  assign k_ext    = CW'(q_off);
  assign kp1      = k_ext + CW'(1);
  // Slot of the byte k back from the newest, wrapped into the ring
  assign back_sum = (CW+1)'(wslot) + (CW+1)'(FULL_CNT) - (CW+1)'(kp1);
  assign recent_addr = ((CW+1)'(wslot) >= (CW+1)'(kp1))
                     ? AW'((CW+1)'(wslot) - (CW+1)'(kp1)) : AW'(back_sum);

  // Sequencer and counters
  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    wr_idx_next     = wr_idx;
    wslot_next      = wslot;
    rslot_next      = rslot;
    unread_next     = unread;
    recent_next     = recent;
    out_valid_next  = out_valid && !out_ready;
    out_status_next = out_status;
    out_byte_next   = out_byte;
    out_count_next  = out_count;
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = wslot;
    raddr  = rslot;
    wbyte  = cmd.bytes[wr_idx];
    q_pop  = 1'b0;

    unique case (state)
      ST_WR: begin
        mem_we = 1'b1;
        wslot_next = (wslot == LAST_SLOT) ? '0 : wslot + AW'(1);
        // Full ring: oldest unread byte is overwritten, drag the read slot
        if (unread == FULL_CNT) begin
          rslot_next = (rslot == LAST_SLOT) ? '0 : rslot + AW'(1);
        end else begin
          unread_next = unread + CW'(1);
        end
        if (recent != FULL_CNT) recent_next = recent + CW'(1);
        wr_idx_next = wr_idx + 3'd1;
        if (wr_idx == cmd.nbytes - 3'd1) begin
          out_valid_next  = 1'b1;
          out_status_next = STAT_OK;
          out_byte_next   = 8'd0;
          out_count_next  = '0;
          state_next      = ST_IDLE;
        end
      end
      ST_RD: begin
        out_valid_next  = 1'b1;
        out_status_next = STAT_OK;
        out_byte_next   = rdata;
        out_count_next  = '0;
        state_next      = ST_IDLE;
      end
      default: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          out_status_next = STAT_OK;
          out_byte_next   = 8'd0;
          out_count_next  = '0;
          out_valid_next  = 1'b1;
          unique case (q_cmd.kind)
            REQ_WRITE: begin
              if (q_cmd.nbytes != 3'd0) begin
                out_valid_next = 1'b0;
                cmd_next       = q_cmd;
                wr_idx_next    = 3'd0;
                state_next     = ST_WR;
              end
            end
            REQ_READ_NEXT: begin
              if (unread == '0) begin
                out_status_next = STAT_EMPTY;
              end else begin
                out_valid_next = 1'b0;
                mem_re = 1'b1;
                raddr  = rslot;
                rslot_next  = (rslot == LAST_SLOT) ? '0 : rslot + AW'(1);
                unread_next = unread - CW'(1);
                state_next  = ST_RD;
              end
            end
            REQ_READ_RECENT: begin
              if (k_ext >= recent) begin
                out_status_next = STAT_RANGE;
              end else begin
                out_valid_next = 1'b0;
                mem_re = 1'b1;
                raddr  = recent_addr;
                state_next = ST_RD;
              end
            end
            REQ_COUNT: begin
              out_count_next = unread;
            end
            REQ_CLEAR: begin
              recent_next = '0;
            end
            default: begin
              out_status_next = STAT_OK;
            end
          endcase
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_idx    <= 3'd0;
      wslot     <= '0;
      rslot     <= '0;
      unread    <= '0;
      recent    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wr_idx    <= wr_idx_next;
      wslot     <= wslot_next;
      rslot     <= rslot_next;
      unread    <= unread_next;
      recent    <= recent_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    out_status <= out_status_next;
    out_byte   <= out_byte_next;
    out_count  <= out_count_next;
  end

  // Ring memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wbyte;
    if (mem_re) rdata <= mem[raddr];
  end

  a_unread_bound: assert property (@(posedge clk) disable iff (rst) unread <= FULL_CNT)
    else $error("unread count above ring depth");
  a_recent_bound: assert property (@(posedge clk) disable iff (rst) recent <= FULL_CNT)
    else $error("recent count above ring depth");
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !out_valid)
    else $error("result pending while back is busy");
  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> state == ST_RD)
    else $error("memory read not followed by read state");

endmodule

### src/log_ring_buffer_with_level_tags_core.sv
// Top level of the byte log ring with line-level tags.
// Depends on lrb_pkg, lrb_if, lrb_front, lrb_queue and lrb_back.
//
//   port       dir    handshake      carries
//   req        sink   valid/ready    req_type, data_byte, last_of_message, back_offset
//   rsp        source valid/ready    status, read_byte, unread_count
//   cfg_*      in     cfg_we only    default_level (3 bits)
//
// Count, clear, unused codes and failed reads are answered from the idle state in the back
// end; a read also passes the read state (registered memory read); a write pops and then
// stores its 0 to 6 bytes one at a time through the single memory write port.
// The front accepts while the two-entry queue has room, so it keeps taking items
// while a result waits.
// Reset (rst, synchronous) clears pointers, counts and line state; ring
// contents are left as they are and are never read before written.
module log_ring_buffer_with_level_tags_core import lrb_pkg::*; #(
  parameter int LOG_DEPTH = 16384
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  lrb_req_if.sink    req,
  lrb_rsp_if.source  rsp
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int OW = AW;

  lrb_cmd_t      front_cmd, head_cmd;
  logic [OW-1:0] head_off;
  logic          q_full, q_nonempty, q_pop, take;

  assign req.ready = !q_full;
  assign take      = req.valid && !q_full;

  lrb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .take            (take),
    .req_type        (req.req_type),
    .data_byte       (req.data_byte),
    .last_of_message (req.last_of_message),
    .cmd             (front_cmd)
  );

  lrb_queue #(.OW(OW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_cmd (front_cmd),
    .push_off (OW'(req.back_offset)),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_cmd (head_cmd),
    .head_off (head_off)
  );

  lrb_back #(
    .LOG_DEPTH (LOG_DEPTH),
    .AW        (AW),
    .CW        (CW),
    .OW        (OW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_nonempty),
    .q_cmd      (head_cmd),
    .q_off      (head_off),
    .q_pop      (q_pop),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_byte   (rsp.read_byte),
    .out_count  (rsp.unread_count)
  );

endmodule

### tb/sv/tb_log_ring_buffer_with_level_tags_core.sv
// Testbench for log_ring_buffer_with_level_tags_core: drives request items, predicts each
// response with its own model of the tagged log ring, and checks responses in order.
// Depends on lrb_pkg, lrb_if and the core RTL.
module tb_log_ring_buffer_with_level_tags_core import lrb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16384;
  localparam int OW = 14;
  localparam int CW = 15;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]    kind;
    logic [7:0]    data;
    logic          last;
    logic [OW-1:0] offset;
  } log_req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [7:0]    rd_byte;
    logic [CW-1:0] count;
  } log_rsp_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  lrb_req_if #(.OW(OW)) req_ch ();
  lrb_rsp_if #(.CW(CW)) rsp_ch ();

  log_ring_buffer_with_level_tags_core #(.LOG_DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Ring model state
  logic [7:0]    ring_mem [DEPTH];
  logic [CW-1:0] wr_pos = '0;
  logic [CW-1:0] rd_pos = '0;
  logic [CW-1:0] recent_n = '0;
  logic          line_start = 1'b1;
  logic [1:0]    held_n = '0;
  logic [7:0]    held_ch = '0;
  logic [2:0]    level = 3'd4;

  log_rsp_t due_q [$];
  int       mismatches = 0;
  int       rsp_seen = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  int       hold_requests = 0;
  int       holds_served = 0;
  int       rx_level = 4;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  longint   cycles = 0;

  // Store one byte; positions run modulo twice the depth (natural 15-bit wrap)
  function automatic void ring_put(logic [7:0] c);
    logic [CW-1:0] unread;
    ring_mem[wr_pos[OW-1:0]] = c;
    wr_pos = wr_pos + 1'b1;
    unread = wr_pos - rd_pos;
    if (unread > DEPTH) rd_pos = wr_pos - CW'(DEPTH);
    if (recent_n < DEPTH) recent_n = recent_n + 1'b1;
  endfunction

  function automatic void put_level_tag();
    ring_put(CH_OPEN);
    ring_put(CH_ZERO + {5'd0, level});
    ring_put(CH_CLOSE);
  endfunction

  // Line-start tag detection for one write byte
  function automatic void apply_write(logic [7:0] b, logic last);
    if (!line_start) begin
      ring_put(b);
      line_start = (b == CH_NL);
      return;
    end
    if (held_n == 2'd1) begin
      if (b >= CH_ZERO && b <= CH_SEVEN && !last) begin
        held_ch = b;
        held_n = 2'd2;
        return;
      end
      put_level_tag();
      ring_put(CH_OPEN);
    end else if (held_n == 2'd2) begin
      if (b == CH_CLOSE) begin
        ring_put(CH_OPEN);
        ring_put(held_ch);
        ring_put(CH_CLOSE);
        held_n = 2'd0;
        line_start = 1'b0;
        return;
      end
      put_level_tag();
      ring_put(CH_OPEN);
      ring_put(held_ch);
    end else begin
      if (b == CH_OPEN && !last) begin
        held_n = 2'd1;
        return;
      end
      put_level_tag();
    end
    held_n = 2'd0;
    ring_put(b);
    line_start = (b == CH_NL);
  endfunction

  // Advance the model by one request item and return the response it must produce
  function automatic log_rsp_t apply_request(log_req_t r);
    log_rsp_t o;
    logic [CW-1:0] p;
    o = '0;
    case (r.kind)
      REQ_WRITE: apply_write(r.data, r.last);
      REQ_READ_NEXT: begin
        if (wr_pos == rd_pos) begin
          o.status = STAT_EMPTY;
        end else begin
          o.rd_byte = ring_mem[rd_pos[OW-1:0]];
          rd_pos = rd_pos + 1'b1;
        end
      end
      REQ_READ_RECENT: begin
        if ({1'b0, r.offset} >= recent_n) begin
          o.status = STAT_RANGE;
        end else begin
          p = wr_pos - {1'b0, r.offset} - 1'b1;
          o.rd_byte = ring_mem[p[OW-1:0]];
        end
      end
      REQ_COUNT: o.count = wr_pos - rd_pos;
      REQ_CLEAR: recent_n = '0;
      default: ;
    endcase
    return o;
  endfunction

  function automatic log_req_t mk_write(logic [7:0] b, logic last);
    log_req_t r;
    r = '0;
    r.kind = REQ_WRITE;
    r.data = b;
    r.last = last;
    r.offset = OW'($urandom);
    return r;
  endfunction

  function automatic log_req_t mk_query(logic [2:0] kind, logic [OW-1:0] offset);
    log_req_t r;
    r.kind = kind;
    r.data = 8'($urandom);
    r.last = 1'($urandom);
    r.offset = offset;
    return r;
  endfunction

  // Message text: mostly printable, with newlines and tag characters mixed in
  function automatic logic [7:0] text_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 8'($urandom_range(32, 126));
    if (pick < 65) return CH_NL;
    if (pick < 75) return CH_OPEN;
    if (pick < 85) return CH_CLOSE;
    return 8'($urandom);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at response %0d: %s got %0d want %0d", rsp_seen, what, got, want);
  endtask

  // Offer one item in bursts with random gaps; predict on acceptance
  task automatic send_item(log_req_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= it.kind;
    req_ch.data_byte <= it.data;
    req_ch.last_of_message <= it.last;
    req_ch.back_offset <= it.offset;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    due_q.push_back(apply_request(it));
    items_sent++;
  endtask

  // Stop offering and wait until every response is in, then let the back end settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_level(logic [2:0] lvl);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_we <= 1'b0;
    level = lvl;
  endtask

  // One request outside the message flow, mostly reads; offsets aim near the recent count
  task automatic send_query();
    int pick;
    logic [OW-1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_item(mk_query(REQ_READ_NEXT, OW'($urandom)));
    end else if (pick < 70) begin
      if ($urandom_range(0, 2) == 0) k = OW'($urandom);
      else k = OW'($urandom_range(0, (recent_n + 2 > DEPTH - 1) ? DEPTH - 1 : recent_n + 2));
      send_item(mk_query(REQ_READ_RECENT, k));
    end else if (pick < 85) begin
      send_item(mk_query(REQ_COUNT, OW'($urandom)));
    end else if (pick < 90) begin
      send_item(mk_query(REQ_CLEAR, OW'($urandom)));
    end else if (pick < 95) begin
      send_item(mk_query(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), OW'($urandom)));
    end else begin
      send_item(mk_write(8'($urandom), 1'($urandom)));
    end
  endtask

  // A message shaped around the line-start tag: good tags, broken tags, no tag, noise
  task automatic send_message();
    logic [7:0] msg [$];
    int shape;
    int len;
    shape = $urandom_range(0, 9);
    case (shape)
      0, 1, 2, 3: begin
        msg.push_back(CH_OPEN);
        msg.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
        msg.push_back(CH_CLOSE);
      end
      5: begin
        msg.push_back(CH_OPEN);
        msg.push_back(text_char());
      end
      6: begin
        msg.push_back(CH_OPEN);
        msg.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
        msg.push_back(text_char());
      end
      7: begin
        msg.push_back(CH_OPEN);
        if ($urandom_range(0, 1) == 1) msg.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      8: begin
        msg.push_back(CH_OPEN);
        msg.push_back(8'(CH_ZERO + $urandom_range(8, 9)));
      end
      default: ;
    endcase
    if (shape != 7) begin
      len = $urandom_range(0, 8);
      repeat (len) msg.push_back(text_char());
      if ($urandom_range(0, 2) != 0) msg.push_back(CH_NL);
    end
    if (msg.size() == 0) msg.push_back(text_char());
    foreach (msg[i]) begin
      if ($urandom_range(0, 9) == 0) send_query();
      send_item(mk_write(msg[i], i == msg.size() - 1));
    end
  endtask

  // Directed: requests against an empty ring and unused codes
  task automatic test_empty_reads();
    send_item(mk_query(REQ_READ_NEXT, '0));
    send_item(mk_query(REQ_READ_RECENT, '0));
    send_item(mk_query(REQ_COUNT, '1));
    send_item(mk_query(REQ_SPARE_LO, '1));
    send_item(mk_query(REQ_SPARE_HI, '0));
  endtask

  // Directed: kept tag, broken tags, and messages ending while bytes are held
  task automatic test_tag_cases();
    send_item(mk_write(CH_OPEN, 1'b0));
    send_item(mk_write(8'h33, 1'b0));
    send_item(mk_write(CH_CLOSE, 1'b0));
    send_item(mk_write(8'h41, 1'b0));
    send_item(mk_write(CH_NL, 1'b1));
    // '<' then a non-digit
    send_item(mk_write(CH_OPEN, 1'b0));
    send_item(mk_write(CH_NL, 1'b0));
    // "<6" then something other than '>'
    send_item(mk_write(CH_OPEN, 1'b0));
    send_item(mk_write(8'h36, 1'b0));
    send_item(mk_write(8'hFF, 1'b0));
    send_item(mk_write(CH_NL, 1'b1));
    // message ends on '<'
    send_item(mk_write(CH_OPEN, 1'b1));
    send_item(mk_write(8'h00, 1'b0));
    send_item(mk_write(CH_NL, 1'b1));
    // message ends on the digit
    send_item(mk_write(CH_OPEN, 1'b0));
    send_item(mk_write(CH_SEVEN, 1'b1));
  endtask

  // Directed: reads, offset extremes, count and clear
  task automatic test_queries();
    send_item(mk_query(REQ_READ_NEXT, '0));
    send_item(mk_query(REQ_READ_RECENT, '0));
    send_item(mk_query(REQ_READ_RECENT, '1));
    send_item(mk_query(REQ_COUNT, '0));
    send_item(mk_query(REQ_CLEAR, '0));
    send_item(mk_query(REQ_READ_RECENT, '0));
  endtask

  task automatic test_random_traffic(int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 6) send_message();
      else send_query();
    end
  endtask

  // Receiver holds off a long stretch while items keep coming, then everything drains
  task automatic test_backpressure();
    hold_requests++;
    test_random_traffic(40);
    drain();
  endtask

  // Bulk short lines, each storing a default tag and a newline, mixed with reads and counts
  task automatic test_bulk_writes();
    int pick;
    logic [OW-1:0] k;
    for (int i = 0; i < 650; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_item(mk_write(CH_NL, 1'b1));
      end else if (pick < 85) begin
        send_item(mk_write(8'($urandom_range(32, 126)), 1'b0));
        send_item(mk_write(CH_NL, 1'b1));
      end else if (pick < 91) begin
        send_item(mk_query(REQ_READ_NEXT, '0));
      end else if (pick < 95) begin
        send_item(mk_query(REQ_COUNT, '0));
      end else if (pick < 99) begin
        k = OW'($urandom_range(0, (recent_n + 2 > DEPTH - 1) ? DEPTH - 1 : recent_n + 2));
        send_item(mk_query(REQ_READ_RECENT, k));
      end else begin
        repeat (8) send_item(mk_query(REQ_READ_NEXT, '0));
      end
    end
    send_item(mk_query(REQ_READ_RECENT, '1));
    send_item(mk_query(REQ_COUNT, '0));
    send_item(mk_query(REQ_CLEAR, '0));
    send_item(mk_query(REQ_READ_RECENT, '0));
  endtask

  // Response side: stall pattern in modes, plus long hold-offs on request
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_mode_left == 0) begin
      rx_mode_left = $urandom_range(20, 80);
      rx_level = $urandom_range(1, 4);
    end
    rx_mode_left--;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 3) < rx_level);
    end
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin : rsp_check
    log_rsp_t want;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (due_q.size() == 0) begin
        report_mismatch("response with nothing pending", 1, 0);
      end else begin
        want = due_q.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", rsp_ch.status, want.status);
        if (rsp_ch.read_byte !== want.rd_byte)
          report_mismatch("read_byte", rsp_ch.read_byte, want.rd_byte);
        if (rsp_ch.unread_count !== want.count)
          report_mismatch("unread_count", rsp_ch.unread_count, want.count);
      end
      rsp_seen++;
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_WRITE;
    req_ch.data_byte = '0;
    req_ch.last_of_message = 1'b0;
    req_ch.back_offset = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_reads();
    test_tag_cases();
    test_queries();
    set_level(3'd0);
    test_random_traffic(400);
    set_level(3'd7);
    test_backpressure();
    test_random_traffic(400);
    set_level(3'd2);
    test_bulk_writes();
    set_level(3'd5);
    test_random_traffic(300);
    drain();

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### log_ring_buffer_with_level_tags_core.f
src/lrb_pkg.sv
src/lrb_if.sv
src/lrb_front.sv
src/lrb_queue.sv
src/lrb_back.sv
src/log_ring_buffer_with_level_tags_core.sv
tb/sv/tb_log_ring_buffer_with_level_tags_core.sv
